[src/fmm_pkg.sv]
// ----------------------------------------------------------------------------
// fmm_pkg
// Shared types for the fixed-point row matrix multiplier: the transaction
// opcodes and the control bundle that the sequencer hands to the
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
package fmm_pkg;

  // Input transaction opcodes, carried in in_tuser
  typedef enum logic [1:0] {
    OP_WR_LEFT  = 2'd0,
    OP_WR_RIGHT = 2'd1,
    OP_COMPUTE  = 2'd2,
    OP_CLR_LEFT = 2'd3
  } op_t;

  // Per-term control for the multiply-accumulate unit
  typedef struct packed {
    logic valid;  // operand pair present at the unit inputs
    logic first;  // first term of a dot product: restart the sum
    logic last;   // final term of a dot product: mark the sum done
    logic take;   // finished sum consumed by the sequencer
  } mac_ctl_t;

endpackage

[src/fmm_store.sv]
// ----------------------------------------------------------------------------
// fmm_store
// Element store: one write port, one registered read port, and a valid bit
// per entry so that reset and a clear make every entry read as zero.
// ----------------------------------------------------------------------------
module fmm_store #(
  parameter int DEPTH  = 60,
  parameter int DATA_W = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;
  logic [DATA_W-1:0] rdata_r;
  logic              rvalid_r;

  // Write the array and read it through a register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // Track written entries; clear drops them all at once
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      rvalid_r <= valid_r[raddr];
    end
  end

  assign rdata = rvalid_r ? rdata_r : '0;

endmodule

[src/fmm_mac.sv]
// ----------------------------------------------------------------------------
// fmm_mac
// Shared multiply-accumulate unit: one registered product per cycle, an exact
// wide sum, then rounding to Q16.16 (half toward plus infinity) and
// saturation to DATA_W signed bits.
// ----------------------------------------------------------------------------
module fmm_mac
  import fmm_pkg::*;
#(
  parameter int DATA_W = 32,
  parameter int TERMS  = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  output logic                     done,
  output logic signed [DATA_W-1:0] result
);

  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int ACC_W     = PROD_W + $clog2(TERMS) + 1;
  localparam int SH_W      = ACC_W - FRAC_BITS;

  logic signed [PROD_W-1:0] prod_r;
  logic                     pv_r;
  logic                     pf_r;
  logic                     pl_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     done_r;
  logic [ACC_W-1:0]         rnd;
  logic [SH_W-1:0]          sh;
  logic [SH_W-DATA_W:0]     hi;

  // Product stage
  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      prod_r <= a * b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      pf_r <= 1'b0;
      pl_r <= 1'b0;
    end else begin
      pv_r <= ctl.valid;
      pf_r <= ctl.first;
      pl_r <= ctl.last;
    end
  end

  // Accumulate stage; restart the sum on the first term
  always_ff @(posedge clk) begin
    if (pv_r) begin
      acc_r <= (pf_r ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);
    end
  end

  // Hold the done mark until the sequencer takes the sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else if (pv_r && pl_r) begin
      done_r <= 1'b1;
    end else if (ctl.take) begin
      done_r <= 1'b0;
    end
  end

  // Round to nearest, ties up, then saturate
  always_comb begin
    rnd = acc_r + ACC_W'(1 << (FRAC_BITS - 1));
    sh  = rnd[ACC_W-1:FRAC_BITS];
    hi  = sh[SH_W-1:DATA_W-1];
    if (&hi || !(|hi)) begin
      result = sh[DATA_W-1:0];
    end else if (!sh[SH_W-1]) begin
      result = {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      result = {1'b1, {(DATA_W-1){1'b0}}};
    end
  end

  assign done = done_r;

endmodule

[src/fixed_matrix_multiply_10x6_unit.sv]
// ----------------------------------------------------------------------------
// fixed_matrix_multiply_10x6_unit
// Q16.16 row-at-a-time matrix multiplier. Loads single elements of a left
// matrix and a right operand, clears the left matrix, and for a compute item
// emits the saturated dot products of one left row with the first columns
// of the right operand, the last one marked.
//
//   channel  dir  ports                  content (low bit up)
//   in_      in   tvalid/tready/tdata    row(4) col(4) value(32) cols(4) pad(4)
//                 tuser                  opcode(2)
//   out_     out  tvalid/tready/tdata    row(4) col(4) value(32)
//                 tlast                  last element of the row
//
// For a compute item, one shared multiply-accumulate unit walks the INNER_DIM
// terms of each column through the memory read, product and sum registers.
// in_tready is low while a row is computed. A stalled output holds the
// sequencer before the next column is loaded. Reset is synchronous, active
// low, and both stores read as zero after it.
// ----------------------------------------------------------------------------
module fixed_matrix_multiply_10x6_unit
  import fmm_pkg::*;
#(
  parameter int LEFT_ROWS      = 10,
  parameter int INNER_DIM      = 6,
  parameter int MAX_RIGHT_COLS = 10,
  parameter int DATA_WIDTH     = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // row_index(4) col_index(4) element_value(32)
                                  // result_cols(4) zero(4)
  input  logic [1:0]  in_tuser,   // opcode(2)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_row(4) out_col(4) product_value(32)
  output logic        out_tlast
);

  localparam int LDEPTH = LEFT_ROWS * INNER_DIM;
  localparam int RDEPTH = INNER_DIM * MAX_RIGHT_COLS;
  localparam int LA_W   = (LDEPTH > 1) ? $clog2(LDEPTH) : 1;
  localparam int RA_W   = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
  localparam int K_W    = (INNER_DIM > 1) ? $clog2(INNER_DIM) : 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [3:0]       row_r, row_nxt;
  logic [4:0]       ncols_r, ncols_nxt;
  logic [3:0]       j_r, j_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  mac_ctl_t         issue_r, issue_nxt;
  mac_ctl_t         mac_ctl;

  logic             out_valid_r;
  logic [3:0]       out_row_r;
  logic [3:0]       out_col_r;
  logic [31:0]      out_val_r;
  logic             out_last_r;

  logic [3:0]       in_row;
  logic [3:0]       in_col;
  logic [31:0]      in_val;
  logic [3:0]       in_cols;
  op_t              in_op;
  logic             in_acc;
  logic             left_ok;
  logic             right_ok;
  logic             start_cmp;
  logic             l_we;
  logic             r_we;
  logic             l_clr;
  logic [LA_W-1:0]  l_waddr;
  logic [RA_W-1:0]  r_waddr;
  logic [LA_W-1:0]  l_raddr;
  logic [RA_W-1:0]  r_raddr;
  logic signed [DATA_WIDTH-1:0] l_rdata;
  logic signed [DATA_WIDTH-1:0] r_rdata;
  logic signed [DATA_WIDTH-1:0] mac_res;
  logic             mac_done;
  logic             load;
  logic             col_last;

  // Unpack the input transaction
  assign in_row  = in_tdata[3:0];
  assign in_col  = in_tdata[7:4];
  assign in_val  = in_tdata[39:8];
  assign in_cols = in_tdata[43:40];
  assign in_op   = op_t'(in_tuser);
  assign in_acc  = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  // Bounds checks for left and right writes
  assign left_ok  = ({1'b0, in_row} < 5'(LEFT_ROWS)) && ({1'b0, in_col} < 5'(INNER_DIM));
  assign right_ok = ({1'b0, in_row} < 5'(INNER_DIM)) &&
                    ({1'b0, in_col} < 5'(MAX_RIGHT_COLS));

  // Decode the opcode into store writes, a left clear and a compute start
  always_comb begin
    l_we      = 1'b0;
    r_we      = 1'b0;
    l_clr     = 1'b0;
    start_cmp = 1'b0;
    unique case (in_op)
      OP_WR_LEFT:  l_we  = in_acc && left_ok;
      OP_WR_RIGHT: r_we  = in_acc && right_ok;
      OP_CLR_LEFT: l_clr = in_acc;
      OP_COMPUTE:  start_cmp = in_acc && ({1'b0, in_row} < 5'(LEFT_ROWS)) &&
                               (in_cols != 4'd0);
      default:     start_cmp = 1'b0;
    endcase
  end

  assign l_waddr = LA_W'(int'(in_row) * INNER_DIM + int'(in_col));
  assign r_waddr = RA_W'(int'(in_row) * MAX_RIGHT_COLS + int'(in_col));
  assign l_raddr = LA_W'(int'(row_r) * INNER_DIM + int'(k_r));
  assign r_raddr = RA_W'(int'(k_r) * MAX_RIGHT_COLS + int'(j_r));

  fmm_store #(
    .DEPTH  (LDEPTH),
    .DATA_W (DATA_WIDTH)
  ) u_left (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (l_clr),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (in_val[DATA_WIDTH-1:0]),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  fmm_store #(
    .DEPTH  (RDEPTH),
    .DATA_W (DATA_WIDTH)
  ) u_right (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (1'b0),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (in_val[DATA_WIDTH-1:0]),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  // Line the term control up with the registered store data
  always_comb begin
    mac_ctl       = issue_r;
    mac_ctl.take  = load;
  end

  fmm_mac #(
    .DATA_W (DATA_WIDTH),
    .TERMS  (INNER_DIM)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .a      (l_rdata),
    .b      (r_rdata),
    .done   (mac_done),
    .result (mac_res)
  );

  assign col_last = ({1'b0, j_r} == (ncols_r - 5'd1));
  assign load     = (state_r == S_DRAIN) && mac_done && (!out_valid_r || out_tready);

  // Sequencer: issue the terms of one column, then wait for the sum
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    ncols_nxt = ncols_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    issue_nxt = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start_cmp) begin
          row_nxt   = in_row;
          ncols_nxt = ({1'b0, in_cols} > 5'(MAX_RIGHT_COLS)) ? 5'(MAX_RIGHT_COLS) :
                      {1'b0, in_cols};
          j_nxt     = '0;
          k_nxt     = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        issue_nxt.valid = 1'b1;
        issue_nxt.first = (k_r == '0);
        issue_nxt.last  = (k_r == K_W'(INNER_DIM - 1));
        if (k_r == K_W'(INNER_DIM - 1)) begin
          k_nxt     = '0;
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + K_W'(1);
        end
      end
      S_DRAIN: begin
        if (load) begin
          if (col_last) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt     = j_r + 4'd1;
            state_nxt = S_RUN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      issue_r <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      issue_r <= issue_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r   <= row_nxt;
    ncols_r <= ncols_nxt;
  end

  // Output register: load a finished column, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_row_r  <= row_r;
      out_col_r  <= j_r;
      out_val_r  <= 32'(mac_res);
      out_last_r <= col_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_val_r, out_col_r, out_row_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  // A sum is only taken once the unit has finished it
  a_take_done: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> mac_done)
    else $error("result loaded before the dot product finished");

  // The column counter stays inside the requested columns while running
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> ({1'b0, j_r} < ncols_r))
    else $error("column counter past the requested columns");

  // A valid compute transaction starts the term walk on the next cycle
  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    start_cmp |=> (state_r == S_RUN) && (j_r == 4'd0) && (k_r == '0))
    else $error("compute transaction did not start the sequencer");
`endif

endmodule
